@@ hdl/vhd_pkg.sv @@
// Shared types and constants for the voxel hash downsampler.
// No dependencies; compile first.
package vhd_pkg;

	localparam int NUM_BUCKETS = 512;
	localparam int BKT_W       = $clog2(NUM_BUCKETS);
	localparam int KEY_W       = 48;
	localparam int CNT_W       = 24;
	localparam int SUM_W       = 56;
	localparam int COORD_W     = 32;
	localparam int VS_W        = 31;
	localparam int APB_AW      = 3;

	localparam logic [VS_W-1:0]  VS_RESET  = VS_W'(13107);
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	// Function codes of an input item
	localparam logic [1:0] F_BOUNDS = 2'd0;
	localparam logic [1:0] F_INSERT = 2'd1;
	localparam logic [1:0] F_DRAIN  = 2'd2;
	localparam logic [1:0] F_NEW    = 2'd3;

	// Result status codes
	localparam logic [1:0] S_EVICT = 2'd0;
	localparam logic [1:0] S_DRAIN = 2'd1;
	localparam logic [1:0] S_EMPTY = 2'd2;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef struct packed {
		logic                        used;
		logic [KEY_W-1:0]            key;
		logic [CNT_W-1:0]            cnt;
		logic [2:0][SUM_W-1:0]       sum;
	} row_t;

endpackage

@@ hdl/vhd_if.sv @@
// Point and result channel interfaces for the voxel hash downsampler.
// Depends on vhd_pkg.
interface vhd_pt_if;
	import vhd_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  func;
	coord_t      x;
	coord_t      y;
	coord_t      z;
	logic [8:0]  bucket;
	modport source (output valid, func, x, y, z, bucket, input ready);
	modport sink   (input valid, func, x, y, z, bucket, output ready);
endinterface

interface vhd_res_if;
	import vhd_pkg::*;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	coord_t      mean_x;
	coord_t      mean_y;
	coord_t      mean_z;
	modport source (output valid, status, mean_x, mean_y, mean_z, input ready);
	modport sink   (input valid, status, mean_x, mean_y, mean_z, output ready);
endinterface

@@ hdl/voxel_hash_downsampler_core.sv @@
// Top level of the voxel hash downsampler: sequencer, shared divide/multiply
// unit, bucket table memory and APB register. Depends on vhd_pkg and vhd_if.
//
// Usage:
//   pt  (sink)  : point items; func selects bounds point, insert point,
//                 drain bucket or start new cloud. A transfer happens when
//                 valid and ready are both high.
//   res (source): centroid results (evicted, drained, or empty bucket),
//                 held in an output register until the receiver takes it.
//   APB         : one register, voxel_size at address 0 (Q15.16, 31 bits).
// Work per item, done by one shared restoring divider / shift-add multiplier: a
// division is a load, 56 steps and a post step; a multiplication has the same load and post:
//   bounds point   updates the corners directly on acceptance
//   insert point   4 divisions, 2 multiplies and a table access,
//                  two more divisions on the first insert of a cloud (for the
//                  grid dimensions), plus 3 divisions when a collision evicts
//                  a centroid
//   drain          3 divisions for a used bucket, none for an empty one
//   new cloud      a clearing pass over the 512 table rows
// Reset runs the same clearing pass; pt.ready stays low meanwhile.
// A result waiting in the output register does not stop new transfers; the
// sequencer only holds in its emit step while that register is occupied.
module voxel_hash_downsampler_core (
	input  logic                       clk,
	input  logic                       arst_n,
	vhd_pt_if.sink                     pt,
	vhd_res_if.source                  res,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [vhd_pkg::APB_AW-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);
	import vhd_pkg::*;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_CLR  = 4'd1;
	localparam logic [3:0] ST_LOAD = 4'd2;
	localparam logic [3:0] ST_UNIT = 4'd3;
	localparam logic [3:0] ST_POST = 4'd4;
	localparam logic [3:0] ST_RD   = 4'd5;
	localparam logic [3:0] ST_CHK  = 4'd6;
	localparam logic [3:0] ST_ACC  = 4'd7;
	localparam logic [3:0] ST_NEW  = 4'd8;
	localparam logic [3:0] ST_FREE = 4'd9;
	localparam logic [3:0] ST_WR   = 4'd10;
	localparam logic [3:0] ST_EMIT = 4'd11;

	// Operations of the shared unit, in sequence order
	localparam logic [3:0] OP_DX = 4'd0;
	localparam logic [3:0] OP_DY = 4'd1;
	localparam logic [3:0] OP_DZ = 4'd2;
	localparam logic [3:0] OP_HX = 4'd3;
	localparam logic [3:0] OP_HY = 4'd4;
	localparam logic [3:0] OP_HZ = 4'd5;
	localparam logic [3:0] OP_MT = 4'd6;
	localparam logic [3:0] OP_MK = 4'd7;
	localparam logic [3:0] OP_MX = 4'd8;
	localparam logic [3:0] OP_MY = 4'd9;
	localparam logic [3:0] OP_MZ = 4'd10;

	localparam logic [5:0] DIV_LAST = 6'(SUM_W - 1);
	localparam logic [5:0] MUL_LAST = 6'(COORD_W - 1);

	logic [3:0]         state_q;
	logic [3:0]         op_q;
	logic [BKT_W-1:0]   clr_q;
	logic [BKT_W-1:0]   bkt_q;
	logic [VS_W-1:0]    vs_q;
	logic [1:0]         func_q;
	coord_t             p_q [3];
	coord_t             min_q [3];
	coord_t             max_q [3];
	logic               seen_q;
	logic               dims_ok_q;
	logic [31:0]        dx_q, dy_q, dz_q;
	logic [31:0]        hx_q, hy_q, hz_q;
	logic [KEY_W-1:0]   t_q;
	logic [KEY_W-1:0]   key_q;
	logic [1:0]         ax_q;
	logic [1:0]         status_q;
	logic [31:0]        mean_q [3];
	logic               neg_q;
	row_t               row_q;
	row_t               rd_q;
	row_t               mem [NUM_BUCKETS];

	// shared unit
	logic [KEY_W-1:0]   un_a_q;
	logic [SUM_W-1:0]   un_b_q;
	logic [KEY_W-1:0]   un_d_q;
	logic               mul_q;
	logic [5:0]         cnt_q;

	logic               out_vq;
	logic [1:0]         out_status_q;
	logic [31:0]        out_m_q [3];

	logic               pt_acc;
	logic               out_free;
	logic [1:0]         ax;
	logic [32:0]        ext, diff;
	logic [SUM_W-1:0]   sel_sum;
	logic [SUM_W-1:0]   ld_b;
	logic [KEY_W-1:0]   ld_d;
	logic               ld_mul;
	logic [VS_W-1:0]    vs_eff;
	logic [31:0]        dv_t;
	logic               dv_ge;
	logic [31:0]        dv_r;
	logic [31:0]        q_sat, q_lo, dim_sel, q_clamp, q_mean;
	logic               q_hi;
	logic               mem_we;
	logic [BKT_W-1:0]   mem_wa;
	row_t               mem_wd;
	logic               key_hit;

	function automatic logic [1:0] ax_of(input logic [3:0] op);
		logic [1:0] r;
		case (op)
			OP_DX, OP_HX, OP_MX: r = 2'd0;
			OP_DY, OP_HY, OP_MY: r = 2'd1;
			default:             r = 2'd2;
		endcase
		return r;
	endfunction

	assign pready   = 1'b1;
	assign prdata   = paddr[2] ? 32'd0 : {1'b0, vs_q};
	assign pt.ready = (state_q == ST_IDLE);
	assign pt_acc   = pt.valid && pt.ready;
	assign out_free = !out_vq || res.ready;

	assign res.valid  = out_vq;
	assign res.status = out_status_q;
	assign res.mean_x = out_m_q[0];
	assign res.mean_y = out_m_q[1];
	assign res.mean_z = out_m_q[2];

	// Operand selection for the shared unit
	always_comb begin
		ax      = ax_of(op_q);
		vs_eff  = (vs_q == '0) ? VS_W'(1) : vs_q;
		ext     = {max_q[ax][31], max_q[ax]} - {min_q[ax][31], min_q[ax]};
		diff    = {p_q[ax][31], p_q[ax]} - {min_q[ax][31], min_q[ax]};
		sel_sum = row_q.sum[ax];
		ld_b    = '0;
		ld_d    = '0;
		ld_mul  = 1'b0;
		case (op_q)
			OP_DX, OP_DY, OP_DZ: begin
				ld_b = SUM_W'(ext);
				ld_d = KEY_W'(vs_eff);
			end
			OP_HX, OP_HY, OP_HZ: begin
				ld_b = diff[32] ? '0 : SUM_W'(diff);
				ld_d = KEY_W'(vs_eff);
			end
			OP_MT: begin
				ld_b   = {dy_q, 24'd0};
				ld_d   = KEY_W'(hz_q);
				ld_mul = 1'b1;
			end
			OP_MK: begin
				ld_b   = {dx_q, 24'd0};
				ld_d   = t_q;
				ld_mul = 1'b1;
			end
			default: begin
				ld_b = sel_sum[SUM_W-1] ? (~sel_sum + SUM_W'(1)) : sel_sum;
				ld_d = KEY_W'(row_q.cnt);
			end
		endcase
	end

	// One restoring-division step
	always_comb begin
		dv_t  = {un_a_q[30:0], un_b_q[SUM_W-1]};
		dv_ge = dv_t >= {1'b0, un_d_q[30:0]};
		dv_r  = dv_ge ? (dv_t - {1'b0, un_d_q[30:0]}) : dv_t;
	end

	// Post-processing of a finished quotient
	always_comb begin
		q_hi  = (un_b_q[SUM_W-1:32] != '0);
		q_lo  = un_b_q[31:0];
		q_sat = (q_hi || (&q_lo)) ? 32'hFFFF_FFFF : (q_lo + 32'd1);
		case (op_q)
			OP_HX:   dim_sel = dx_q;
			OP_HY:   dim_sel = dy_q;
			default: dim_sel = dz_q;
		endcase
		q_clamp = (q_hi || (q_lo >= dim_sel)) ? (dim_sel - 32'd1) : q_lo;
		q_mean  = neg_q ? (~q_lo + 32'd1) : q_lo;
	end

	assign key_hit = (rd_q.key == key_q);

	// Bucket table
	assign mem_we = (state_q == ST_CLR) || (state_q == ST_WR);
	assign mem_wa = (state_q == ST_CLR) ? clr_q : bkt_q;
	assign mem_wd = (state_q == ST_CLR) ? row_t'('0) : row_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[bkt_q];
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vs_q <= VS_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			vs_q <= pwdata[VS_W-1:0];
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_q     <= '0;
			seen_q    <= 1'b0;
			dims_ok_q <= 1'b0;
			out_vq    <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				min_q[i] <= '0;
				max_q[i] <= '0;
			end
		end else begin
			// the emit step sets the output register itself
			if (out_vq && res.ready && state_q != ST_EMIT) begin
				out_vq <= 1'b0;
			end
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + BKT_W'(1);
					if (clr_q == BKT_W'(NUM_BUCKETS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (pt_acc) begin
						func_q <= pt.func;
						p_q[0] <= pt.x;
						p_q[1] <= pt.y;
						p_q[2] <= pt.z;
						case (pt.func)
							F_BOUNDS: begin
								// track corners; first point sets both
								if (!seen_q || pt.x < min_q[0]) min_q[0] <= pt.x;
								if (!seen_q || pt.y < min_q[1]) min_q[1] <= pt.y;
								if (!seen_q || pt.z < min_q[2]) min_q[2] <= pt.z;
								if (!seen_q || pt.x > max_q[0]) max_q[0] <= pt.x;
								if (!seen_q || pt.y > max_q[1]) max_q[1] <= pt.y;
								if (!seen_q || pt.z > max_q[2]) max_q[2] <= pt.z;
								seen_q    <= 1'b1;
								dims_ok_q <= 1'b0;
							end
							F_INSERT: begin
								op_q    <= dims_ok_q ? OP_DZ : OP_DX;
								state_q <= ST_LOAD;
							end
							F_DRAIN: begin
								bkt_q   <= pt.bucket[BKT_W-1:0];
								state_q <= ST_RD;
							end
							default: begin
								// new cloud: drop corners and sweep the table
								for (int i = 0; i < 3; i++) begin
									min_q[i] <= '0;
									max_q[i] <= '0;
								end
								seen_q    <= 1'b0;
								dims_ok_q <= 1'b0;
								clr_q     <= '0;
								state_q   <= ST_CLR;
							end
						endcase
					end
				end
				ST_LOAD: begin
					un_a_q  <= '0;
					un_b_q  <= ld_b;
					un_d_q  <= ld_d;
					mul_q   <= ld_mul;
					neg_q   <= sel_sum[SUM_W-1];
					cnt_q   <= '0;
					state_q <= ST_UNIT;
				end
				ST_UNIT: begin
					if (mul_q) begin
						un_a_q <= {un_a_q[KEY_W-2:0], 1'b0} +
							(un_b_q[SUM_W-1] ? un_d_q : '0);
						un_b_q <= {un_b_q[SUM_W-2:0], 1'b0};
					end else begin
						un_a_q <= KEY_W'(dv_r[30:0]);
						un_b_q <= {un_b_q[SUM_W-2:0], dv_ge};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == (mul_q ? MUL_LAST : DIV_LAST)) begin
						state_q <= ST_POST;
					end
				end
				ST_POST: begin
					state_q <= ST_LOAD;
					op_q    <= op_q + 4'd1;
					case (op_q)
						OP_DX: dx_q <= q_sat;
						OP_DY: begin
							dy_q      <= q_sat;
							dims_ok_q <= 1'b1;
						end
						OP_DZ: dz_q <= q_sat;
						OP_HX: hx_q <= q_clamp;
						OP_HY: hy_q <= q_clamp;
						OP_HZ: hz_q <= q_clamp;
						OP_MT: t_q  <= un_a_q + KEY_W'(hy_q);
						OP_MK: begin
							key_q   <= un_a_q + KEY_W'(hx_q);
							bkt_q   <= un_a_q[BKT_W-1:0] + hx_q[BKT_W-1:0];
							state_q <= ST_RD;
						end
						OP_MX: mean_q[0] <= q_mean;
						OP_MY: mean_q[1] <= q_mean;
						default: begin
							mean_q[2] <= q_mean;
							state_q   <= ST_EMIT;
						end
					endcase
				end
				ST_RD: begin
					state_q <= ST_CHK;
				end
				ST_CHK: begin
					row_q <= rd_q;
					ax_q  <= '0;
					if (func_q == F_DRAIN) begin
						if (!rd_q.used) begin
							status_q <= S_EMPTY;
							for (int i = 0; i < 3; i++) mean_q[i] <= '0;
							state_q  <= ST_EMIT;
						end else begin
							status_q <= S_DRAIN;
							op_q     <= OP_MX;
							state_q  <= ST_LOAD;
						end
					end else if (!rd_q.used) begin
						state_q <= ST_NEW;
					end else if (key_hit) begin
						// saturated bucket ignores further points
						state_q <= (rd_q.cnt == COUNT_MAX) ? ST_IDLE : ST_ACC;
					end else begin
						status_q <= S_EVICT;
						op_q     <= OP_MX;
						state_q  <= ST_LOAD;
					end
				end
				ST_ACC: begin
					row_q.sum[ax_q] <= row_q.sum[ax_q] + SUM_W'(p_q[ax_q]);
					ax_q <= ax_q + 2'd1;
					if (ax_q == 2'd2) begin
						row_q.cnt <= row_q.cnt + CNT_W'(1);
						state_q   <= ST_WR;
					end
				end
				ST_NEW: begin
					row_q.used <= 1'b1;
					row_q.key  <= key_q;
					row_q.cnt  <= CNT_W'(1);
					for (int i = 0; i < 3; i++) row_q.sum[i] <= SUM_W'(p_q[i]);
					state_q <= ST_WR;
				end
				ST_FREE: begin
					row_q.used <= 1'b0;
					state_q    <= ST_WR;
				end
				ST_WR: begin
					state_q <= ST_IDLE;
				end
				ST_EMIT: begin
					// hold until the output register can take the result
					if (out_free) begin
						out_vq       <= 1'b1;
						out_status_q <= status_q;
						for (int i = 0; i < 3; i++) out_m_q[i] <= mean_q[i];
						if (func_q == F_INSERT) begin
							state_q <= ST_NEW;
						end else if (status_q == S_DRAIN) begin
							state_q <= ST_FREE;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UNIT) |-> (cnt_q <= DIV_LAST))
		else $error("shared unit ran past its last step");

	a_new_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(pt.valid && pt.ready && pt.func == F_NEW) |=> (state_q == ST_CLR && clr_q == '0))
		else $error("new cloud did not start a clearing pass");

	a_emit_only: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vq && !$past(out_vq)) |-> ($past(state_q) == ST_EMIT))
		else $error("result appeared outside the emit step");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vq && out_status_q == S_EMPTY) |->
		(out_m_q[0] == '0 && out_m_q[1] == '0 && out_m_q[2] == '0))
		else $error("empty-bucket result carries a nonzero centroid");

endmodule
